@@ rtl/xrg_pkg.sv @@
// xrg_pkg: shared types, constants and state encodings for the xoshiro256** generator
// no dependencies; imported by every module under rtl
`timescale 1ns / 1ps

package xrg_pkg;

    localparam int WordW = 64;
    localparam int HalfW = 32;

    localparam logic [WordW-1:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [WordW-1:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [WordW-1:0] MIX_MUL_B  = 64'h94D049BB133111EB;

    localparam logic CMD_NEXT   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    localparam logic [1:0] LAST_INDEX = 2'd3;

    localparam logic [1:0] PHASE_LO    = 2'd0;
    localparam logic [1:0] PHASE_CROSS = 2'd1;
    localparam logic [1:0] PHASE_LAST  = 2'd2;

    // one queued transfer from the request channel
    typedef struct packed {
        logic             command;
        logic [WordW-1:0] seed_value;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [WordW-1:0] seed;
    } seed_req_t;

    // one expanded state word from the seeding unit
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [1:0]       index;
        logic [WordW-1:0] word;
    } seed_wr_t;

    typedef struct packed {
        logic seeding;
        logic pop;
    } core_stat_t;

    typedef enum logic [1:0] {
        MIX_IDLE,
        MIX_ADD,
        MIX_MUL,
        MIX_XOR
    } mix_state_t;

    typedef enum logic [1:0] {
        CORE_INIT,
        CORE_WAIT,
        CORE_RUN
    } core_state_t;

endpackage

@@ rtl/xrg_front.sv @@
// xrg_front: request side, a two-entry queue of command transfers
// depends on xrg_pkg
`timescale 1ns / 1ps

module xrg_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic                     command,
    input  logic [63:0]              seed_value,
    output xrg_pkg::item_t           q_item,
    output logic                     q_valid,
    input  logic                     q_pop
);
    import xrg_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign req_ready = (count_reg != 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = mem_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{command: command, seed_value: seed_value};
        end
    end

endmodule

@@ rtl/xrg_mix.sv @@
// xrg_mix: SplitMix64 seeding unit, one 32x32 partial product per cycle
// depends on xrg_pkg; emits the four state words in order
`timescale 1ns / 1ps

module xrg_mix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  xrg_pkg::seed_req_t   req,
    output xrg_pkg::seed_wr_t    wr
);
    import xrg_pkg::*;

    mix_state_t       state_reg, state_next;
    logic [WordW-1:0] acc_reg, acc_next;
    logic [WordW-1:0] z_reg, z_next;
    logic [WordW-1:0] prod_reg, prod_next;
    logic [1:0]       phase_reg, phase_next;
    logic             round_reg, round_next;
    logic [1:0]       index_reg, index_next;

    logic [WordW-1:0] acc_inc;
    logic [WordW-1:0] mul_const;
    logic [HalfW-1:0] mul_x, mul_y;
    logic [WordW-1:0] mul_full;
    logic [WordW-1:0] mix_mid, mix_out;

    assign acc_inc   = acc_reg + GOLDEN_INC;
    assign mul_const = round_reg ? MIX_MUL_B : MIX_MUL_A;
    assign mul_full  = {32'd0, mul_x} * {32'd0, mul_y};
    assign mix_mid   = prod_reg ^ (prod_reg >> 27);
    assign mix_out   = prod_reg ^ (prod_reg >> 31);

    // low 64 bits of z * c: lo*lo, then the two cross terms shifted up
    always_comb
    begin
        case (phase_reg)
            PHASE_LO:
            begin
                mul_x = z_reg[HalfW-1:0];
                mul_y = mul_const[HalfW-1:0];
            end
            PHASE_CROSS:
            begin
                mul_x = z_reg[WordW-1:HalfW];
                mul_y = mul_const[HalfW-1:0];
            end
            default:
            begin
                mul_x = z_reg[HalfW-1:0];
                mul_y = mul_const[WordW-1:HalfW];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        z_next     = z_reg;
        prod_next  = prod_reg;
        phase_next = phase_reg;
        round_next = round_reg;
        index_next = index_reg;
        wr         = '{valid: 1'b0, last: 1'b0, index: index_reg, word: mix_out};
        case (state_reg)
            MIX_IDLE:
            begin
                if (req.start)
                begin
                    acc_next   = req.seed;
                    index_next = 2'd0;
                    state_next = MIX_ADD;
                end
            end
            MIX_ADD:
            begin
                acc_next   = acc_inc;
                z_next     = acc_inc ^ (acc_inc >> 30);
                round_next = 1'b0;
                phase_next = PHASE_LO;
                state_next = MIX_MUL;
            end
            MIX_MUL:
            begin
                if (phase_reg == PHASE_LO)
                begin
                    prod_next = mul_full;
                end
                else
                begin
                    prod_next = prod_reg + {mul_full[HalfW-1:0], 32'd0};
                end
                if (phase_reg == PHASE_LAST)
                begin
                    state_next = MIX_XOR;
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            MIX_XOR:
            begin
                if (!round_reg)
                begin
                    z_next     = mix_mid;
                    round_next = 1'b1;
                    phase_next = PHASE_LO;
                    state_next = MIX_MUL;
                end
                else
                begin
                    wr.valid = 1'b1;
                    wr.last  = (index_reg == LAST_INDEX);
                    if (index_reg == LAST_INDEX)
                    begin
                        state_next = MIX_IDLE;
                    end
                    else
                    begin
                        index_next = index_reg + 2'd1;
                        state_next = MIX_ADD;
                    end
                end
            end
            default:
            begin
                state_next = MIX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MIX_IDLE;
            phase_reg <= PHASE_LO;
            round_reg <= 1'b0;
            index_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        z_reg    <= z_next;
        prod_reg <= prod_next;
    end

endmodule

@@ rtl/xrg_core.sv @@
// xrg_core: back end, holds the four state words, scrambles and advances on next
// depends on xrg_pkg; drives xrg_mix for reseed and the power-up seeding pass
`timescale 1ns / 1ps

module xrg_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  xrg_pkg::item_t       q_item,
    input  logic                 q_valid,
    output logic                 q_pop,
    output xrg_pkg::seed_req_t   seed_req,
    input  xrg_pkg::seed_wr_t    seed_wr,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [63:0]          random_word,
    output xrg_pkg::core_stat_t  stat
);
    import xrg_pkg::*;

    core_state_t      state_reg, state_next;
    logic [WordW-1:0] s_reg [4];
    logic             rsp_valid_reg, rsp_valid_next;
    logic [WordW-1:0] random_word_reg;

    logic             slot_free;
    logic             advance;
    logic [WordW-1:0] mul5, rot7, scrambled;
    logic [WordW-1:0] t, n0, n1, n2, n3;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    // rotl(s1 * 5, 7) * 9 as shift-adds
    assign mul5      = s_reg[1] + (s_reg[1] << 2);
    assign rot7      = {mul5[56:0], mul5[63:57]};
    assign scrambled = rot7 + (rot7 << 3);

    assign t  = s_reg[1] << 17;
    assign n2 = s_reg[2] ^ s_reg[0];
    assign n3 = s_reg[3] ^ s_reg[1];
    assign n1 = s_reg[1] ^ n2;
    assign n0 = s_reg[0] ^ n3;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        advance    = 1'b0;
        seed_req   = '{start: 1'b0, seed: q_item.seed_value};
        case (state_reg)
            CORE_INIT:
            begin
                seed_req.start = 1'b1;
                seed_req.seed  = '0;
                state_next     = CORE_WAIT;
            end
            CORE_WAIT:
            begin
                if (seed_wr.valid && seed_wr.last)
                begin
                    state_next = CORE_RUN;
                end
            end
            CORE_RUN:
            begin
                if (q_valid)
                begin
                    if (q_item.command == CMD_RESEED)
                    begin
                        q_pop          = 1'b1;
                        seed_req.start = 1'b1;
                        state_next     = CORE_WAIT;
                    end
                    else if (slot_free)
                    begin
                        q_pop   = 1'b1;
                        advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = CORE_INIT;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CORE_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seed_wr.valid)
        begin
            s_reg[seed_wr.index] <= seed_wr.word;
        end
        else if (advance)
        begin
            s_reg[0] <= n0;
            s_reg[1] <= n1;
            s_reg[2] <= n2 ^ t;
            s_reg[3] <= {n3[18:0], n3[63:19]};
        end
        if (advance)
        begin
            random_word_reg <= scrambled;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign random_word = random_word_reg;
    assign stat        = '{seeding: (state_reg != CORE_RUN), pop: q_pop};

endmodule

@@ rtl/xoshiro256_random_generator.sv @@
// xoshiro256_random_generator: xoshiro256** generator with SplitMix64 seeding
// Request channel: req_valid/req_ready with command and seed_value. command next
// asks for one random_word; command reseed loads the state from seed_value and
// gives no response. Response channel: rsp_valid/rsp_ready with random_word.
// Requests land in a two-entry queue, so up to two transfers are taken while
// the back end is busy or the response side stalls.
// Next: the request is registered in the queue, popped by the back end, and
// its word lands in the single response register with rsp_valid; a run of
// next commands sustains one response per cycle while rsp_ready stays high.
// Reseed: the back end waits on the seeding unit, which does each 64-bit
// multiply as three 32x32 partial products for each of the four state words.
// Reset: the state is loaded by a seeding pass with seed zero; requests
// queue up meanwhile and are served once it ends.
// Receiver stall: the response register holds its word; the back end takes no
// further next command until the word is transferred, and the queue fills.
// depends on xrg_pkg, xrg_front, xrg_mix, xrg_core
`timescale 1ns / 1ps

module xoshiro256_random_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        command,
    input  logic [63:0] seed_value,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [63:0] random_word
);
    import xrg_pkg::*;

    item_t      q_item;
    logic       q_valid;
    logic       q_pop;
    seed_req_t  seed_req;
    seed_wr_t   seed_wr;
    core_stat_t stat;

    xrg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .command    (command),
        .seed_value (seed_value),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop)
    );

    xrg_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (seed_req),
        .wr    (seed_wr)
    );

    xrg_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (q_item),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .seed_req    (seed_req),
        .seed_wr     (seed_wr),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .random_word (random_word),
        .stat        (stat)
    );

    // queue never popped empty
    assert property (@(posedge clk) disable iff (!rst_n) stat.pop |-> q_valid)
        else $error("queue popped while empty");

    // seeding unit writes state only while the back end waits for it
    assert property (@(posedge clk) disable iff (!rst_n) seed_wr.valid |-> stat.seeding)
        else $error("state word written while running");

    // a new response only follows a pop of a next command
    assert property (@(posedge clk) disable iff (!rst_n) $rose(rsp_valid) |-> $past(stat.pop))
        else $error("response without a popped command");

    // an empty queue always takes a transfer
    assert property (@(posedge clk) disable iff (!rst_n) !q_valid |-> req_ready)
        else $error("empty queue refused a transfer");

endmodule
